// ----- sv/md5_stream_hash_assert.svh -----
// ----------------------------------------------------------------------------
// md5_stream_hash assertion macros
// Shared property macros for the stream hash checker.
// ----------------------------------------------------------------------------
`ifndef MD5_STREAM_HASH_ASSERT_SVH
`define MD5_STREAM_HASH_ASSERT_SVH

// assert that antecedent implies consequent on the next edge
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// assert that an expression holds on every edge
`define MD5_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`endif

// ----- sv/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// md5_pkg
// Types, constants and step tables for the MD5 stream hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD,
		ST_EMIT
	} md5_state_t;

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD80,
		SRC_ZERO,
		SRC_LEN
	} md5_src_t;

	typedef struct packed {
		logic     wr_byte;
		md5_src_t src;
		logic     add_len;
		logic     comp_start;
		logic     comp_step;
		logic     comp_fold;
		logic     restart;
	} md5_cmd_t;

	typedef struct packed {
		logic       block_full;
		logic [5:0] fill_pos;
		logic       comp_last;
	} md5_status_t;

	function automatic logic [31:0] step_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
			32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
			32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
			32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
			32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
			32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
			32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
			32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
			32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
			32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
			32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
			32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
			32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
			32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
			32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
			32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
		};
		return k[i];
	endfunction

	function automatic logic [4:0] step_rot(input logic [5:0] i);
		logic [4:0] r [16];
		r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
			5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
		return r[{i[5:4], i[1:0]}];
	endfunction

	function automatic logic [3:0] step_word(input logic [5:0] i);
		logic [3:0] g;
		unique case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(5 * i[3:0] + 1);
			2'd2: g = 4'(3 * i[3:0] + 5);
			default: g = 4'(7 * i[3:0]);
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

// ----- sv/md5_stream_hash.sv -----
// A data byte is written into the block buffer on its transfer; the byte that completes a block stalls input
// for the round. A finish pads one byte per cycle and runs the round once or twice;
// the digest is then presented and holds until taken.
// Bytes are taken one per cycle within a block, but input stalls while the single round unit runs.
// Reset: arst_n clears the chaining words to the initial vector, count and fill to zero.
// ----------------------------------------------------------------------------
// md5_stream_hash
// Top level: MD5 over a byte stream with a digest per finish transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module md5_stream_hash
	import md5_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // data_byte[7:0]
	input  wire logic         s_tuser,   // kind
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata    // digest_low[63:0], digest_high[127:64]
);

	md5_cmd_t    cmd;
	md5_status_t status;

	md5_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready), .in_kind(s_tuser),
		.out_fire(m_tvalid && m_tready), .status(status),
		.in_ready(s_tready), .out_valid(m_tvalid), .cmd(cmd)
	);

	md5_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(s_tdata),
		.status(status), .digest(m_tdata)
	);

endmodule
`default_nettype wire

// ----- sv/md5_datapath.sv -----
// ----------------------------------------------------------------------------
// md5_datapath
// Block buffer, bit counter, chaining words and the one-step-per-cycle round.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module md5_datapath
	import md5_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire md5_cmd_t     cmd,
	input  wire logic [7:0]   data_byte,
	output md5_status_t       status,
	output logic [127:0]      digest
);

	logic [31:0] words_q [16];
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [63:0] len_snap_q;
	logic [31:0] ch_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  step_q;
	logic [7:0]  wr_val;
	logic [31:0] f, t, rot;
	logic [4:0]  s;

	always_comb begin
		unique case (cmd.src)
			SRC_DATA:  wr_val = data_byte;
			SRC_PAD80: wr_val = PAD_BYTE;
			SRC_ZERO:  wr_val = 8'h00;
			default:   wr_val = len_snap_q[8 * (fill_q[2:0]) +: 8];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			words_q[fill_q[5:2]][8 * fill_q[1:0] +: 8] <= wr_val;
		end
	end

	always_comb begin
		unique case (step_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		t = a_q + f + words_q[step_word(step_q)] + step_k(step_q);
		s = step_rot(step_q);
		rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q <= '0;
			step_q <= '0;
			ch_q <= '{IV_A, IV_B, IV_C, IV_D};
		end else begin
			if (cmd.wr_byte) fill_q <= fill_q + 6'd1;
			if (cmd.add_len) len_q <= len_q + 64'd8;
			if (cmd.comp_start) step_q <= '0;
			else if (cmd.comp_step) step_q <= step_q + 6'd1;
			if (cmd.comp_fold) begin
				ch_q[0] <= ch_q[0] + d_q;
				ch_q[1] <= ch_q[1] + b_q + rot;
				ch_q[2] <= ch_q[2] + b_q;
				ch_q[3] <= ch_q[3] + c_q;
			end
			if (cmd.restart) begin
				ch_q <= '{IV_A, IV_B, IV_C, IV_D};
				len_q <= '0;
				fill_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.src == SRC_PAD80 && cmd.wr_byte) len_snap_q <= len_q;
		if (cmd.comp_start) begin
			a_q <= ch_q[0];
			b_q <= ch_q[1];
			c_q <= ch_q[2];
			d_q <= ch_q[3];
		end else if (cmd.comp_step) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot;
		end
	end

	assign status.block_full = (fill_q == 6'd63);
	assign status.fill_pos = fill_q;
	assign status.comp_last = (step_q == 6'd63);
	assign digest = {ch_q[3], ch_q[2], ch_q[1], ch_q[0]};

endmodule
`default_nettype wire

// ----- sv/md5_ctrl.sv -----
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer for byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module md5_ctrl
	import md5_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_fire,
	input  wire logic        in_kind,
	input  wire logic        out_fire,
	input  wire md5_status_t status,
	output logic             in_ready,
	output logic             out_valid,
	output md5_cmd_t         cmd
);

	md5_state_t state_q, state_d;
	logic       fin_q, fin_d;
	logic       wrap_q, wrap_d;
	logic       lenwrote_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q <= 1'b0;
			wrap_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q <= fin_d;
			wrap_q <= wrap_d;
		end
	end

	always_comb begin
		state_d = state_q;
		fin_d = fin_q;
		wrap_d = wrap_q;
		cmd = '0;
		cmd.src = SRC_DATA;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.wr_byte = 1'b1;
					if (in_kind) begin
						cmd.src = SRC_PAD80;
						fin_d = 1'b1;
						if (status.fill_pos >= LEN_POS && !status.block_full) wrap_d = 1'b1;
					end else begin
						cmd.add_len = 1'b1;
					end
					if (status.block_full) begin
						cmd.comp_start = 1'b1;
						state_d = ST_COMP;
					end else if (in_kind) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_COMP: begin
				cmd.comp_step = 1'b1;
				if (status.comp_last) begin
					cmd.comp_fold = 1'b1;
					state_d = fin_q ? ST_PAD : ST_IDLE;
				end
			end
			ST_PAD: begin
				cmd.wr_byte = 1'b1;
				cmd.src = (status.fill_pos >= LEN_POS && !wrap_q) ? SRC_LEN : SRC_ZERO;
				if (status.block_full) begin
					cmd.comp_start = 1'b1;
					state_d = ST_COMP;
					wrap_d = 1'b0;
					if (cmd.src == SRC_LEN) fin_d = 1'b0;
				end
			end
			default: begin
				out_valid = 1'b1;
				if (out_fire) begin
					cmd.restart = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
		if (state_q == ST_COMP && status.comp_last && !fin_q && state_d == ST_IDLE &&
			lenwrote_q) begin
			state_d = ST_EMIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lenwrote_q <= 1'b0;
		else if (state_q == ST_PAD && status.block_full && cmd.src == SRC_LEN)
			lenwrote_q <= 1'b1;
		else if (state_q == ST_EMIT) lenwrote_q <= 1'b0;
	end

endmodule
`default_nettype wire

// ----- sv/md5_stream_hash_checker.sv -----
// ----------------------------------------------------------------------------
// md5_stream_hash_checker
// Port-level checks for the stream hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "md5_stream_hash_assert.svh"
module md5_stream_hash_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata
);

	`MD5_ASSERT_ALWAYS(a_no_overlap, clk, arst_n, !(m_tvalid && s_tready))
	`MD5_ASSERT_NEXT(a_finish_busy, clk, arst_n, s_tvalid && s_tready && s_tuser, !s_tready)
	`MD5_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`MD5_ASSERT_NEXT(a_out_done, clk, arst_n, m_tvalid && m_tready, !m_tvalid)

endmodule

bind md5_stream_hash md5_stream_hash_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
